/* src/serial_frame_receiver_crc8_top_assert.svh */
// Assertion macros for the framed serial receiver.
// Depends on nothing; the asserting module supplies i_clk and i_rst_n.
`ifndef SERIAL_FRAME_RECEIVER_CRC8_TOP_ASSERT_SVH
`define SERIAL_FRAME_RECEIVER_CRC8_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define SFR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define SFR_NEVER(lbl, cond, msg) \
    `SFR_ASSERT(lbl, !(cond), msg)
`else
`define SFR_ASSERT(lbl, prop, msg)
`define SFR_NEVER(lbl, cond, msg)
`endif
`endif

/* src/sfr_crc8_pkg.sv */
// Shared types, frame constants and CRC-8 helpers for the serial receiver.
// No dependencies.
package sfr_crc8_pkg;

    localparam logic [7:0] HDR0     = 8'h55;
    localparam logic [7:0] HDR1     = 8'hAA;
    localparam logic [7:0] CRC_POLY = 8'h8C;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CRC,
        ST_RD,
        ST_WAIT,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        MODE_HUNT,
        MODE_RECV,
        MODE_CHECK,
        MODE_TRAIL
    } t_mode;

    function automatic logic [7:0] crc8_shift(input logic [7:0] v);
        crc8_shift = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
    endfunction

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            v = crc8_shift(v);
        end
        crc8_byte = v;
    endfunction

    localparam logic [7:0] HDR_CRC = crc8_byte(crc8_byte(8'h00, HDR0), HDR1);

endpackage

/* src/sfr_crc8_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sfr_crc8_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 40
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* src/serial_frame_receiver_crc8_top.sv */
// Hunt, last-payload, CRC-check and trailer bytes are accepted directly; the length byte and
// the CRC-covered payload bytes are each followed by the bit-serial CRC shifter (ST_CRC).
// The final trailer byte starts the word readout: each word is read byte by byte from the
// payload RAM (ST_RD), loaded (ST_WAIT) and then held in ST_OUT until it is taken.
// Input is held off while the CRC shifter runs and during the word readout.
// Reset (synchronous, active low) clears sequencer, mode, position, hunt byte and CRC;
// the payload RAM is not cleared and needs no clearing pass.
`include "serial_frame_receiver_crc8_top_assert.svh"
module serial_frame_receiver_crc8_top #(
    parameter int PAYLOAD_WORDS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [3:0] word_index, [35:4] word_bits, [39:36] zero
    output logic        m_axis_tlast    // last_word
);
    import sfr_crc8_pkg::*;

    localparam int PAYLOAD_BYTES = 4 * PAYLOAD_WORDS;
    localparam int CRC_POS       = 3 + PAYLOAD_BYTES;
    localparam int FRAME_BYTES   = CRC_POS + 3;
    localparam int POS_W         = $clog2(FRAME_BYTES + 1);
    localparam int ADDR_W        = $clog2(PAYLOAD_BYTES);

    t_state             r_state, n_state;
    t_mode              r_mode, n_mode;
    logic [POS_W-1:0]   r_byte_pos, n_byte_pos;
    logic [7:0]         r_prev_byte, n_prev_byte;
    logic [7:0]         r_crc, n_crc;
    logic [2:0]         r_bit_cnt, n_bit_cnt;
    logic [3:0]         r_word_idx, n_word_idx;
    logic [1:0]         r_byte_cnt, n_byte_cnt;
    logic               r_rd_pend;
    logic [31:0]        r_word;
    logic               ram_we, ram_re;
    logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
    logic [7:0]         ram_rdata;
    logic               in_acc;
    logic               out_acc;
    logic               crc_due;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;
    assign crc_due = (r_mode == MODE_RECV) && (r_byte_pos < POS_W'(CRC_POS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mode      <= MODE_HUNT;
            r_byte_pos  <= '0;
            r_prev_byte <= '0;
            r_crc       <= '0;
            r_bit_cnt   <= '0;
            r_word_idx  <= '0;
            r_byte_cnt  <= '0;
            r_rd_pend   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_byte_pos  <= n_byte_pos;
            r_prev_byte <= n_prev_byte;
            r_crc       <= n_crc;
            r_bit_cnt   <= n_bit_cnt;
            r_word_idx  <= n_word_idx;
            r_byte_cnt  <= n_byte_cnt;
            r_rd_pend   <= ram_re;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_pend) begin
            r_word <= {ram_rdata, r_word[31:8]};
        end
    end

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_byte_pos  = r_byte_pos;
        n_prev_byte = r_prev_byte;
        n_crc       = r_crc;
        n_bit_cnt   = r_bit_cnt;
        n_word_idx  = r_word_idx;
        n_byte_cnt  = r_byte_cnt;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_waddr   = ADDR_W'(r_byte_pos - POS_W'(3));
        ram_raddr   = ADDR_W'({r_word_idx, r_byte_cnt});
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (r_mode)
                        MODE_HUNT: begin
                            if (r_prev_byte == HDR0 && s_axis_tdata == HDR1) begin
                                n_crc      = HDR_CRC;
                                n_byte_pos = POS_W'(2);
                                n_mode     = MODE_RECV;
                            end
                            n_prev_byte = s_axis_tdata;
                        end
                        MODE_RECV: begin
                            ram_we = (r_byte_pos >= POS_W'(3)) &&
                                     (r_byte_pos < POS_W'(CRC_POS));
                            if (crc_due) begin
                                n_crc     = r_crc ^ s_axis_tdata;
                                n_bit_cnt = '0;
                                n_state   = ST_CRC;
                            end
                            n_byte_pos = r_byte_pos + POS_W'(1);
                            if (r_byte_pos == POS_W'(CRC_POS - 1)) begin
                                n_mode = MODE_CHECK;
                            end
                        end
                        MODE_CHECK: begin
                            if (s_axis_tdata == r_crc) begin
                                n_byte_pos = r_byte_pos + POS_W'(1);
                                n_mode     = MODE_TRAIL;
                            end else begin
                                n_byte_pos = '0;
                                n_mode     = MODE_HUNT;
                            end
                        end
                        MODE_TRAIL: begin
                            if (r_byte_pos == POS_W'(FRAME_BYTES - 1)) begin
                                n_byte_pos = '0;
                                n_mode     = MODE_HUNT;
                                n_word_idx = '0;
                                n_byte_cnt = '0;
                                n_state    = ST_RD;
                            end else begin
                                n_byte_pos = r_byte_pos + POS_W'(1);
                            end
                        end
                        default: n_mode = MODE_HUNT;
                    endcase
                end
            end
            ST_CRC: begin
                n_crc     = crc8_shift(r_crc);
                n_bit_cnt = r_bit_cnt + 3'd1;
                if (r_bit_cnt == 3'd7) begin
                    n_state = ST_IDLE;
                end
            end
            ST_RD: begin
                ram_re     = 1'b1;
                n_byte_cnt = r_byte_cnt + 2'd1;
                if (r_byte_cnt == 2'd3) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: n_state = ST_OUT;
            ST_OUT: begin
                if (out_acc) begin
                    if (r_word_idx == 4'(PAYLOAD_WORDS - 1)) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_word_idx = r_word_idx + 4'd1;
                        n_state    = ST_RD;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    sfr_crc8_ram #(
        .WIDTH (8),
        .DEPTH (PAYLOAD_BYTES)
    ) u_payload_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (s_axis_tdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = (r_state == ST_OUT);
    assign m_axis_tdata  = {4'b0000, r_word, r_word_idx};
    assign m_axis_tlast  = (r_word_idx == 4'(PAYLOAD_WORDS - 1));

    `SFR_NEVER(a_no_overlap, s_axis_tready && m_axis_tvalid, "input taken during word readout")
    `SFR_ASSERT(a_emit_in_hunt, m_axis_tvalid |-> r_mode == MODE_HUNT, "readout outside hunt")
    `SFR_ASSERT(a_pos_bound, r_byte_pos < POS_W'(FRAME_BYTES), "byte position overrun")
    `SFR_ASSERT(a_word_gap, out_acc && !m_axis_tlast |=> r_state == ST_RD, "reads skipped")
    `SFR_ASSERT(a_crc_busy, in_acc && crc_due |=> r_state == ST_CRC, "CRC shift not started")
endmodule
